/* design/bbc_pkg.sv */
// Package for the edge-normalized 5x5 box blur core.
// Holds field widths, register indexes, request codes and parameter defaults.
// No dependencies.
package bbc_pkg;

  localparam int PIX_W     = 8;
  localparam int NUM_CH    = 3;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_MAX_WIDTH = 256;
  localparam int DEF_RADIUS    = 2;

  // Reset value of both frame size registers.
  localparam int CFG_RESET_SIZE = 256;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

endpackage

/* design/bbc_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the pixel history of the box blur core. No dependencies.
module bbc_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/box_blur_5x5_clipped_core.sv */
// An input transfer that completes an output passes through a setup state, the tap reads,
//   a drain state, the bit-serial divide and the output load before out_valid_o (RADIUS 2: 25 taps).
// An item that yields no result leaves the core idle and ready for the next item; an item that
//   yields one stalls the input while the single read port of the history RAM reads its taps
//   (one tap per cycle), the bit-serial divider runs and out_stall_i may hold the result load.
// Reset clears all control state and sets the frame to 256x256 (width capped at MAX_WIDTH); the RAM is not cleared.
module box_blur_5x5_clipped_core #(
  parameter int MAX_WIDTH = bbc_pkg::DEF_MAX_WIDTH,
  parameter int RADIUS    = bbc_pkg::DEF_RADIUS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [bbc_pkg::PIX_W-1:0]     red_in_i,
  input  logic [bbc_pkg::PIX_W-1:0]     green_in_i,
  input  logic [bbc_pkg::PIX_W-1:0]     blue_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bbc_pkg::PIX_W-1:0]     red_out_o,
  output logic [bbc_pkg::PIX_W-1:0]     green_out_o,
  output logic [bbc_pkg::PIX_W-1:0]     blue_out_o,
  output logic                          frame_done_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bbc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bbc_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int PW     = bbc_pkg::PIX_W;
  localparam int NCH    = bbc_pkg::NUM_CH;
  localparam int HW     = bbc_pkg::CFG_W;
  localparam int SPAN   = 2 * RADIUS + 1;
  localparam int TAPS   = SPAN * SPAN;
  localparam int HIST   = 2 * RADIUS * MAX_WIDTH + 2 * RADIUS + 1;
  localparam int AW     = $clog2(HIST);
  localparam int EW     = $clog2(MAX_WIDTH + 1);
  localparam int POS_W  = $clog2(MAX_WIDTH * ((1 << HW) - 1) + 1);
  localparam int SUM_W  = $clog2(TAPS * ((1 << PW) - 1) + 1);
  localparam int CNT_W  = $clog2(TAPS + 1);
  localparam int SI_W   = $clog2(SPAN);
  localparam int DC_W   = $clog2(SUM_W);
  localparam int RST_W  = (bbc_pkg::CFG_RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH
                                                                : bbc_pkg::CFG_RESET_SIZE;

  localparam logic [AW:0]       HIST_E   = (AW + 1)'(HIST);
  localparam logic [SI_W-1:0]   TAP_LAST = SI_W'(SPAN - 1);
  localparam logic [DC_W-1:0]   DIV_LAST = DC_W'(SUM_W - 1);
  localparam logic [HW+1:0]     ROW_R    = (HW + 2)'(RADIUS);
  localparam logic [EW+1:0]     COL_R    = (EW + 2)'(RADIUS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_LAST = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= HIST_E) begin
      s = s - HIST_E;
    end
    return s[AW-1:0];
  endfunction

  // Control state
  logic [2:0]       state_q, state_d;
  logic [EW-1:0]    eff_w_q, eff_w_d;
  logic [HW-1:0]    eff_h_q, eff_h_d;
  logic [HW-1:0]    in_row_q, in_row_d;
  logic [EW-1:0]    in_col_q, in_col_d;
  logic [POS_W-1:0] in_pos_q, in_pos_d;
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [HW-1:0]    out_row_q, out_row_d;
  logic [EW-1:0]    out_col_q, out_col_d;
  logic [AW-1:0]    out_ptr_q, out_ptr_d;
  logic             draining_q, draining_d;
  logic             out_valid_q, out_valid_d;
  logic             rd_vld_q;

  // Datapath state
  logic [AW-1:0]    rd_addr_q, rd_addr_d;
  logic [AW-1:0]    row_base_q, row_base_d;
  logic [HW+1:0]    nrow_q, nrow_d;
  logic [EW+1:0]    ncol_q, ncol_d;
  logic [SI_W-1:0]  dx_q, dx_d, dy_q, dy_d;
  logic [DC_W-1:0]  div_cnt_q, div_cnt_d;
  logic             rd_in_q, rd_in_d;
  logic [SUM_W-1:0] sum_q [NCH];
  logic [SUM_W-1:0] sum_d [NCH];
  logic [CNT_W-1:0] rem_q [NCH];
  logic [CNT_W-1:0] rem_d [NCH];
  logic [CNT_W-1:0] count_q, count_d;
  logic [PW-1:0]    res_q [NCH];
  logic [PW-1:0]    res_d [NCH];
  logic             done_q, done_d;

  logic                in_acc, cfg_we, out_load, load_done, restart;
  logic                mem_we, mem_re;
  logic [NCH*PW-1:0]   mem_wdata, mem_rdata;
  logic [POS_W-1:0]    lead_pos;
  logic [AW-1:0]       lead_a;
  logic [AW-1:0]       start_addr;
  logic [HW+1:0]       row_base_pos;
  logic [EW+1:0]       col_base_pos;
  logic                in_last, tap_inside;

  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  assign lead_pos     = POS_W'(eff_w_q) * POS_W'(RADIUS) + POS_W'(RADIUS);
  assign lead_a       = lead_pos[AW-1:0];
  assign start_addr   = wrap_add(out_ptr_q, AW'(HIST) - lead_a);
  assign row_base_pos = {2'b00, out_row_q} - ROW_R;
  assign col_base_pos = {2'b00, out_col_q} - COL_R;

  assign in_last = (in_row_q == eff_h_q - HW'(1)) && (in_col_q == eff_w_q - EW'(1));

  // A neighbor counts only if it lies inside the frame on both axes.
  assign tap_inside = !nrow_q[HW+1] && (nrow_q[HW:0] < {1'b0, eff_h_q}) &&
                      !ncol_q[EW+1] && (ncol_q[EW:0] < {1'b0, eff_w_q});

  assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  assign load_done = (out_row_q == eff_h_q - HW'(1)) && (out_col_q == eff_w_q - EW'(1));
  assign restart   = cfg_we || (out_load && load_done);

  assign mem_we    = in_acc && !draining_q && (req_type_i == bbc_pkg::REQ_PIXEL);
  assign mem_re    = (state_q == S_READ);
  assign mem_wdata = {red_in_i, green_in_i, blue_in_i};

  bbc_ram #(
    .Width (NCH * PW),
    .Depth (HIST),
    .AddrW (AW)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_addr_q),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    logic [CNT_W:0] rem_sh;
    logic [CNT_W:0] rem_sub;
    logic           ge;

    state_d    = state_q;
    eff_w_d    = eff_w_q;
    eff_h_d    = eff_h_q;
    in_row_d   = in_row_q;
    in_col_d   = in_col_q;
    in_pos_d   = in_pos_q;
    wr_ptr_d   = wr_ptr_q;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    out_ptr_d  = out_ptr_q;
    draining_d = draining_q;
    rd_addr_d  = rd_addr_q;
    row_base_d = row_base_q;
    nrow_d     = nrow_q;
    ncol_d     = ncol_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    div_cnt_d  = div_cnt_q;
    rd_in_d    = tap_inside;
    count_d    = count_q;
    done_d     = done_q;
    rem_sh     = '0;
    rem_sub    = '0;
    ge         = 1'b0;
    for (int c = 0; c < NCH; c++) begin
      sum_d[c] = sum_q[c];
      rem_d[c] = rem_q[c];
      res_d[c] = res_q[c];
    end

    if (cfg_we) begin
      unique case (cfg_index_i)
        bbc_pkg::REG_FRAME_WIDTH: begin
          if (cfg_data_i == '0) begin
            eff_w_d = EW'(1);
          end else if (32'(cfg_data_i) > 32'(MAX_WIDTH)) begin
            eff_w_d = EW'(MAX_WIDTH);
          end else begin
            eff_w_d = EW'(cfg_data_i);
          end
        end
        bbc_pkg::REG_FRAME_HEIGHT: begin
          eff_h_d = (cfg_data_i == '0) ? HW'(1) : cfg_data_i;
        end
      endcase
    end

    // Taps that arrive from the RAM in the cycle after their read.
    if (rd_vld_q && rd_in_q) begin
      for (int c = 0; c < NCH; c++) begin
        sum_d[c] = sum_q[c] + SUM_W'(mem_rdata[(NCH-1-c)*PW +: PW]);
      end
      count_d = count_q + CNT_W'(1);
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!draining_q) begin
            if (req_type_i == bbc_pkg::REQ_PIXEL) begin
              wr_ptr_d = wrap_add(wr_ptr_q, AW'(1));
              in_pos_d = in_pos_q + POS_W'(1);
              if (in_col_q == eff_w_q - EW'(1)) begin
                in_col_d = '0;
                in_row_d = in_row_q + HW'(1);
              end else begin
                in_col_d = in_col_q + EW'(1);
              end
              if (in_last) begin
                draining_d = 1'b1;
              end
              if (in_pos_q >= lead_pos) begin
                state_d = S_INIT;
              end
            end
          end else if (req_type_i == bbc_pkg::REQ_FLUSH) begin
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        rd_addr_d  = start_addr;
        row_base_d = start_addr;
        nrow_d     = row_base_pos;
        ncol_d     = col_base_pos;
        dx_d       = '0;
        dy_d       = '0;
        count_d    = '0;
        for (int c = 0; c < NCH; c++) begin
          sum_d[c] = '0;
          rem_d[c] = '0;
        end
        state_d = S_READ;
      end
      S_READ: begin
        if (dx_q == TAP_LAST) begin
          dx_d       = '0;
          dy_d       = dy_q + SI_W'(1);
          ncol_d     = col_base_pos;
          nrow_d     = nrow_q + (HW + 2)'(1);
          row_base_d = wrap_add(row_base_q, AW'(eff_w_q));
          rd_addr_d  = wrap_add(row_base_q, AW'(eff_w_q));
          if (dy_q == TAP_LAST) begin
            state_d = S_LAST;
          end
        end else begin
          dx_d      = dx_q + SI_W'(1);
          ncol_d    = ncol_q + (EW + 2)'(1);
          rd_addr_d = wrap_add(rd_addr_q, AW'(1));
        end
      end
      S_LAST: begin
        div_cnt_d = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle on every channel.
        for (int c = 0; c < NCH; c++) begin
          rem_sh   = {rem_q[c], sum_q[c][SUM_W-1]};
          rem_sub  = rem_sh - {1'b0, count_q};
          ge       = (rem_sh >= {1'b0, count_q});
          rem_d[c] = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
          sum_d[c] = {sum_q[c][SUM_W-2:0], ge};
        end
        div_cnt_d = div_cnt_q + DC_W'(1);
        if (div_cnt_q == DIV_LAST) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          for (int c = 0; c < NCH; c++) begin
            res_d[c] = sum_q[c][PW-1:0];
          end
          done_d    = load_done;
          out_ptr_d = wrap_add(out_ptr_q, AW'(1));
          if (out_col_q == eff_w_q - EW'(1)) begin
            out_col_d = '0;
            out_row_d = out_row_q + HW'(1);
          end else begin
            out_col_d = out_col_q + EW'(1);
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (restart) begin
      in_row_d   = '0;
      in_col_d   = '0;
      in_pos_d   = '0;
      wr_ptr_d   = '0;
      out_row_d  = '0;
      out_col_d  = '0;
      out_ptr_d  = '0;
      draining_d = 1'b0;
    end
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      eff_w_q     <= EW'(RST_W);
      eff_h_q     <= HW'(bbc_pkg::CFG_RESET_SIZE);
      in_row_q    <= '0;
      in_col_q    <= '0;
      in_pos_q    <= '0;
      wr_ptr_q    <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_ptr_q   <= '0;
      draining_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      eff_w_q     <= eff_w_d;
      eff_h_q     <= eff_h_d;
      in_row_q    <= in_row_d;
      in_col_q    <= in_col_d;
      in_pos_q    <= in_pos_d;
      wr_ptr_q    <= wr_ptr_d;
      out_row_q   <= out_row_d;
      out_col_q   <= out_col_d;
      out_ptr_q   <= out_ptr_d;
      draining_q  <= draining_d;
      out_valid_q <= out_valid_d;
      rd_vld_q    <= mem_re;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q  <= rd_addr_d;
    row_base_q <= row_base_d;
    nrow_q     <= nrow_d;
    ncol_q     <= ncol_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    div_cnt_q  <= div_cnt_d;
    rd_in_q    <= rd_in_d;
    count_q    <= count_d;
    done_q     <= done_d;
    for (int c = 0; c < NCH; c++) begin
      sum_q[c] <= sum_d[c];
      rem_q[c] <= rem_d[c];
      res_q[c] <= res_d[c];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = res_q[0];
  assign green_out_o  = res_q[1];
  assign blue_out_o   = res_q[2];
  assign frame_done_o = done_q;

  // The center tap is always inside the frame, so the divisor is never zero.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (count_q != '0))
    else $error("divider started with a zero neighbor count");

  a_rd_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> ({1'b0, rd_addr_q} < HIST_E))
    else $error("history read address out of range");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && load_done) |=> ((in_pos_q == '0) && !draining_q && (wr_ptr_q == '0)))
    else $error("frame state not cleared after the last output of a frame");

endmodule

/* tb/box_blur_5x5_clipped_core_test.sv */
// Self-checking testbench for the streaming 5x5 edge-normalized box blur core.
// Predicts every blurred pixel in SystemVerilog and checks it against the DUT output stream.
// Depends on bbc_pkg and box_blur_5x5_clipped_core.
`timescale 1ns / 100ps

module box_blur_5x5_clipped_core_test;

  localparam int PIX_W      = bbc_pkg::PIX_W;
  localparam int NUM_CH     = bbc_pkg::NUM_CH;
  localparam int CFG_W      = bbc_pkg::CFG_W;
  localparam int CFG_IDX_W  = bbc_pkg::CFG_IDX_W;
  localparam int MAX_W      = bbc_pkg::DEF_MAX_WIDTH;
  localparam int RAD        = bbc_pkg::DEF_RADIUS;
  localparam int HIST_DEPTH = 2 * RAD * MAX_W + 2 * RAD + 1;
  localparam int RGB_W      = NUM_CH * PIX_W;
  // Longer than the core's worst internal latency, so a register write never lands mid-work.
  localparam int SETTLE_CYCLES = 64;
  localparam int SMALL_FRAME_BUDGET = 470;
  localparam int WIDE_FLUSHES = 12;

  typedef enum logic [1:0] {
    STEP_PIXEL,
    STEP_FLUSH,
    STEP_WRITE,
    STEP_HOLD
  } step_kind_e;

  typedef struct packed {
    step_kind_e           kind;
    logic [RGB_W-1:0]     rgb;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } plan_step_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             done;
  } blur_px_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic                 req_type_i  = bbc_pkg::REQ_PIXEL;
  logic [PIX_W-1:0]     red_in_i    = '0;
  logic [PIX_W-1:0]     green_in_i  = '0;
  logic [PIX_W-1:0]     blue_in_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [PIX_W-1:0]     red_out_o;
  logic [PIX_W-1:0]     green_out_o;
  logic [PIX_W-1:0]     blue_out_o;
  logic                 frame_done_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = bbc_pkg::REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_data_i  = '0;

  box_blur_5x5_clipped_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .frame_done_o (frame_done_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  plan_step_t pixel_plan[$];
  blur_px_t   blurred_due[$];

  // Predictor state.
  logic [RGB_W-1:0] hist_mem [HIST_DEPTH];
  int               px_row;
  int               px_col;
  int               out_idx;
  bit               draining;
  logic [CFG_W-1:0] width_reg  = CFG_W'(bbc_pkg::CFG_RESET_SIZE);
  logic [CFG_W-1:0] height_reg = CFG_W'(bbc_pkg::CFG_RESET_SIZE);

  // Geometry as the stimulus generator sees it.
  logic [CFG_W-1:0] gen_w_raw = CFG_W'(bbc_pkg::CFG_RESET_SIZE);
  logic [CFG_W-1:0] gen_h_raw = CFG_W'(bbc_pkg::CFG_RESET_SIZE);

  int  mismatches   = 0;
  int  results_seen = 0;
  int  frames_seen  = 0;
  int  writes_done  = 0;
  int  px_transfers = 0;
  int  steps_done   = 0;
  int  calm_from    = 0;
  bit  calm         = 1'b0;

  function automatic int eff_width(logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_W) return MAX_W;
    return raw;
  endfunction

  function automatic int eff_height(logic [CFG_W-1:0] raw);
    return (raw == 0) ? 1 : raw;
  endfunction

  function automatic void restart_frame();
    px_row   = 0;
    px_col   = 0;
    out_idx  = 0;
    draining = 1'b0;
  endfunction

  // Averages the clipped neighborhood of the next output position.
  function automatic void predict_emit();
    int w, h, y, x, yy, xx, cnt, sr, sg, sb;
    logic [RGB_W-1:0] v;
    blur_px_t p;
    w = eff_width(width_reg);
    h = eff_height(height_reg);
    y = out_idx / w;
    x = out_idx % w;
    cnt = 0;
    sr = 0;
    sg = 0;
    sb = 0;
    for (int dy = -RAD; dy <= RAD; dy++) begin
      for (int dx = -RAD; dx <= RAD; dx++) begin
        yy = y + dy;
        xx = x + dx;
        if (yy >= 0 && yy < h && xx >= 0 && xx < w) begin
          v = hist_mem[(yy * w + xx) % HIST_DEPTH];
          sr += v[2*PIX_W +: PIX_W];
          sg += v[PIX_W +: PIX_W];
          sb += v[0 +: PIX_W];
          cnt++;
        end
      end
    end
    p.red   = PIX_W'(sr / cnt);
    p.green = PIX_W'(sg / cnt);
    p.blue  = PIX_W'(sb / cnt);
    out_idx++;
    p.done = (out_idx >= w * h);
    if (p.done) restart_frame();
    blurred_due.push_back(p);
  endfunction

  function automatic void predict_transfer(logic req, logic [RGB_W-1:0] rgb);
    int w, h, pos;
    w = eff_width(width_reg);
    h = eff_height(height_reg);
    if (draining) begin
      // Data pixels are ignored until the frame has drained.
      if (req == bbc_pkg::REQ_FLUSH) predict_emit();
    end else if (req == bbc_pkg::REQ_PIXEL) begin
      pos = px_row * w + px_col;
      hist_mem[pos % HIST_DEPTH] = rgb;
      px_col++;
      if (px_col >= w) begin
        px_col = 0;
        px_row++;
      end
      if (pos + 1 >= w * h) draining = 1'b1;
      if (pos >= RAD * w + RAD) predict_emit();
    end
  endfunction

  function automatic void predict_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    if (idx == bbc_pkg::REG_FRAME_WIDTH) width_reg = data;
    else height_reg = data;
    restart_frame();
  endfunction

  function automatic void plan_step(step_kind_e kind, logic [RGB_W-1:0] rgb);
    plan_step_t s;
    s.kind = kind;
    s.rgb  = rgb;
    s.idx  = bbc_pkg::REG_FRAME_WIDTH;
    s.data = '0;
    pixel_plan.push_back(s);
  endfunction

  function automatic void plan_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    plan_step_t s;
    s.kind = STEP_WRITE;
    s.rgb  = '0;
    s.idx  = idx;
    s.data = data;
    pixel_plan.push_back(s);
    if (idx == bbc_pkg::REG_FRAME_WIDTH) gen_w_raw = data;
    else gen_h_raw = data;
  endfunction

  function automatic int drain_count();
    int w, total;
    w = eff_width(gen_w_raw);
    total = w * eff_height(gen_h_raw);
    return (total < RAD * w + RAD) ? total : RAD * w + RAD;
  endfunction

  // A whole frame plus the flush ticks that drain it. Noise is early flushes,
  // pixels sent while draining, and pauses until all results are in.
  function automatic int plan_frame(bit noisy);
    int total, drains;
    total  = eff_width(gen_w_raw) * eff_height(gen_h_raw);
    drains = drain_count();
    for (int i = 0; i < total; i++) begin
      if (noisy && $urandom_range(99) < 4) plan_step(STEP_FLUSH, RGB_W'($urandom()));
      if (noisy && $urandom_range(99) < 2) plan_step(STEP_HOLD, '0);
      plan_step(STEP_PIXEL, RGB_W'($urandom()));
    end
    for (int j = 0; j < drains; j++) begin
      if (noisy && $urandom_range(99) < 4) plan_step(STEP_PIXEL, RGB_W'($urandom()));
      plan_step(STEP_FLUSH, RGB_W'($urandom()));
    end
    return total + drains;
  endfunction

  // Stops short of the frame end; the register write that follows aborts it.
  function automatic int plan_partial();
    int total, cut;
    total = eff_width(gen_w_raw) * eff_height(gen_h_raw);
    cut   = $urandom_range(0, total + drain_count() - 1);
    for (int i = 0; i < cut; i++) begin
      plan_step((i < total) ? STEP_PIXEL : STEP_FLUSH, RGB_W'($urandom()));
    end
    if ($urandom_range(1)) plan_write(bbc_pkg::REG_FRAME_WIDTH, gen_w_raw);
    else plan_write(bbc_pkg::REG_FRAME_HEIGHT, CFG_W'($urandom_range(1, 8)));
    return cut;
  endfunction

  function automatic logic [CFG_W-1:0] random_width();
    return ($urandom_range(19) == 0) ? '0 : CFG_W'($urandom_range(1, 12));
  endfunction

  function automatic logic [CFG_W-1:0] random_height();
    return ($urandom_range(19) == 0) ? '0 : CFG_W'($urandom_range(1, 8));
  endfunction

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result %0d, %s expected %0d, got %0d", $realtime, results_seen, what,
                 want, got);
      end
    end
  endfunction

  // Driver for the pixel and register channels.
  int drv_cycles = 0;
  int gap_left   = 0;
  int settle     = 0;
  int send_pct   = 0;

  always @(posedge clk_i) begin
    plan_step_t s;
    bit next_in_v;
    bit next_cfg_v;
    bit calm_now;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        s = pixel_plan.pop_front();
        predict_transfer(req_type_i, {red_in_i, green_in_i, blue_in_i});
        px_transfers++;
        steps_done++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        s = pixel_plan.pop_front();
        predict_write(cfg_index_i, cfg_data_i);
        writes_done++;
        steps_done++;
      end
      calm_now = (steps_done >= calm_from);
      calm <= calm_now;
      drv_cycles++;
      if (drv_cycles % 128 == 0) begin
        case ($urandom_range(3))
          0, 1: send_pct = 0;
          2: send_pct = 15;
          default: send_pct = 40;
        endcase
      end
      if (!(in_valid_i && in_stall_o) && !(cfg_valid_i && !cfg_ready_o)) begin
        next_in_v  = 1'b0;
        next_cfg_v = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pixel_plan.size() > 0) begin
          s = pixel_plan[0];
          case (s.kind)
            STEP_PIXEL, STEP_FLUSH: begin
              if (!calm_now && $urandom_range(99) < send_pct) begin
                gap_left = $urandom_range(0, 9);
              end else begin
                next_in_v = 1'b1;
                req_type_i <= (s.kind == STEP_FLUSH) ? bbc_pkg::REQ_FLUSH : bbc_pkg::REQ_PIXEL;
                red_in_i   <= s.rgb[2*PIX_W +: PIX_W];
                green_in_i <= s.rgb[PIX_W +: PIX_W];
                blue_in_i  <= s.rgb[0 +: PIX_W];
              end
            end
            STEP_WRITE: begin
              if (blurred_due.size() != 0) begin
                settle = 0;
              end else if (settle < SETTLE_CYCLES) begin
                settle++;
              end else begin
                settle = 0;
                next_cfg_v = 1'b1;
                cfg_index_i <= s.idx;
                cfg_data_i  <= s.data;
              end
            end
            default: begin
              if (blurred_due.size() == 0) begin
                s = pixel_plan.pop_front();
                steps_done++;
              end
            end
          endcase
        end
        in_valid_i  <= next_in_v;
        cfg_valid_i <= next_cfg_v;
      end
    end
  end

  // Monitor and checker for the result channel.
  int mon_cycles = 0;
  int stall_left = 0;
  int stall_pct  = 0;

  always @(posedge clk_i) begin
    blur_px_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (frame_done_o) frames_seen++;
        if (blurred_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result %0d arrived with none expected (r %0d g %0d b %0d done %0b)",
                     $realtime, results_seen, red_out_o, green_out_o, blue_out_o,
                     frame_done_o);
          end
        end else begin
          want = blurred_due.pop_front();
          check_field("red", want.red, red_out_o);
          check_field("green", want.green, green_out_o);
          check_field("blue", want.blue, blue_out_o);
          check_field("frame_done", want.done, frame_done_o);
        end
      end
      mon_cycles++;
      if (mon_cycles % 128 == 0) begin
        case ($urandom_range(3))
          0, 1: stall_pct = 0;
          2: stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(0, 9);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int fed;
    bit wide_done;
    fed = 0;
    wide_done = 1'b0;

    // Reset size: a few pixels and an early flush, then a write aborts the frame.
    plan_step(STEP_PIXEL, 24'hFFFFFF);
    plan_step(STEP_FLUSH, 24'h000000);
    plan_step(STEP_PIXEL, 24'h000000);
    // Single-pixel frame; the second flush belongs to the next frame and is ignored.
    plan_write(bbc_pkg::REG_FRAME_WIDTH, CFG_W'(1));
    plan_write(bbc_pkg::REG_FRAME_HEIGHT, CFG_W'(1));
    plan_step(STEP_PIXEL, 24'hFF00FF);
    plan_step(STEP_FLUSH, 24'hFFFFFF);
    plan_step(STEP_FLUSH, 24'h000000);
    // Zero sizes behave as one.
    plan_write(bbc_pkg::REG_FRAME_WIDTH, CFG_W'(0));
    plan_write(bbc_pkg::REG_FRAME_HEIGHT, CFG_W'(0));
    plan_step(STEP_PIXEL, 24'h00FF00);
    plan_step(STEP_HOLD, '0);
    plan_step(STEP_FLUSH, 24'h000000);
    // 3x2 frame with extreme channels and a pixel sent while draining.
    plan_write(bbc_pkg::REG_FRAME_WIDTH, CFG_W'(3));
    plan_write(bbc_pkg::REG_FRAME_HEIGHT, CFG_W'(2));
    plan_step(STEP_PIXEL, 24'hFFFFFF);
    plan_step(STEP_PIXEL, 24'h000000);
    plan_step(STEP_PIXEL, 24'hFFFFFF);
    plan_step(STEP_PIXEL, 24'h000000);
    plan_step(STEP_PIXEL, 24'hFFFFFF);
    plan_step(STEP_PIXEL, 24'hFEFDFC);
    for (int j = 0; j < 6; j++) begin
      if (j == 2) plan_step(STEP_PIXEL, 24'h123456);
      plan_step(STEP_FLUSH, 24'h000000);
    end

    // Random frames, mostly small; one full-width row in between.
    while (fed < SMALL_FRAME_BUDGET) begin
      if (fed >= 100 && !wide_done) begin
        // A width at or beyond the maximum acts as the maximum; the first outputs of the row are checked
        // and a register write then aborts the rest of the drain.
        plan_write(bbc_pkg::REG_FRAME_WIDTH, CFG_W'($urandom_range(MAX_W, 511)));
        plan_write(bbc_pkg::REG_FRAME_HEIGHT, CFG_W'(1));
        for (int i = 0; i < MAX_W; i++) plan_step(STEP_PIXEL, RGB_W'($urandom()));
        for (int j = 0; j < WIDE_FLUSHES; j++) plan_step(STEP_FLUSH, RGB_W'($urandom()));
        plan_write(bbc_pkg::REG_FRAME_WIDTH, random_width());
        fed += MAX_W + WIDE_FLUSHES;
        wide_done = 1'b1;
      end
      if ($urandom_range(1)) plan_write(bbc_pkg::REG_FRAME_WIDTH, random_width());
      if ($urandom_range(1)) plan_write(bbc_pkg::REG_FRAME_HEIGHT, random_height());
      if ($urandom_range(9) == 0) fed += plan_partial();
      else fed += plan_frame($urandom_range(9) < 7);
    end
    calm_from = pixel_plan.size() * 85 / 100;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pixel_plan.size() != 0 || blurred_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Checked %0d blurred pixels over %0d finished frames after %0d register writes.",
             results_seen, frames_seen, writes_done);
    $display("Pixel channel carried %0d transfers, including early flushes and aborted frames.",
             px_transfers);
    if (mismatches == 0) begin
      $display("[box_blur_5x5_clipped_core] OK");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("[box_blur_5x5_clipped_core] ERROR");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Run did not finish in time.");
    $display("[box_blur_5x5_clipped_core] ERROR");
    $finish;
  end

endmodule

/* sim.f */
design/bbc_pkg.sv
design/bbc_ram.sv
design/box_blur_5x5_clipped_core.sv
tb/box_blur_5x5_clipped_core_test.sv
